[sv/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Item types, alphabet lookup and count helpers for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [5:0] SEXTET_62  = 6'd62;
  localparam logic [5:0] SEXTET_63  = 6'd63;
  localparam logic [2:0] PAD_MAX    = 3'd7;
  localparam logic [1:0] HELD_FULL  = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [1:0] byte_count;
    logic       last_group;
    logic       bad_length;
  } out_item_t;

  typedef struct packed {
    logic       hit;     // character is in the alphabet
    logic       is_pad;  // character is '='
    logic [5:0] sextet;
  } map_t;

  // Standard and URL-safe alphabets together; codes of 128 and up never hit.
  function automatic map_t map_char(input logic [7:0] c);
    map_t m;
    m = '{hit: 1'b0, is_pad: 1'b0, sextet: 6'd0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      m.hit = 1'b1;
      m.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      m.hit = 1'b1;
      m.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      m.hit = 1'b1;
      m.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B || c == 8'h2D) begin
      m.hit = 1'b1;
      m.sextet = SEXTET_62;
    end else if (c == 8'h2F || c == 8'h5F) begin
      m.hit = 1'b1;
      m.sextet = SEXTET_63;
    end else if (c == CHAR_PAD) begin
      m.hit = 1'b1;
      m.is_pad = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [1:0] count_for_pad(input logic [2:0] pad);
    logic [1:0] n;
    case (pad)
      3'd0:    n = 2'd3;
      3'd1:    n = 2'd2;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  // Masks bytes beyond the count to zero.
  function automatic out_item_t make_result(input logic [23:0] bits, input logic [1:0] cnt,
                                            input logic last, input logic bad);
    out_item_t r;
    r.byte_first  = (cnt >= 2'd1) ? bits[23:16] : 8'd0;
    r.byte_second = (cnt >= 2'd2) ? bits[15:8]  : 8'd0;
    r.byte_third  = (cnt == 2'd3) ? bits[7:0]   : 8'd0;
    r.byte_count  = cnt;
    r.last_group  = last;
    r.bad_length  = bad;
    return r;
  endfunction

endpackage

[sv/b64d_in_stage.sv]
// ----------------------------------------------------------------------------
// b64d_in_stage
// Input register: captures one item per cycle, holds it while the core stalls.
// ----------------------------------------------------------------------------
module b64d_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  b64d_pkg::in_item_t in_item,
  output logic               in_stall,
  input  logic               advance,
  output logic               hold_valid,
  output b64d_pkg::in_item_t hold_item
);

  logic               valid_r;
  logic               valid_nxt;
  b64d_pkg::in_item_t item_r;

  // Register frees up when empty or when its item moves into the core.
  assign in_stall  = valid_r && !advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

[sv/b64d_group_unit.sv]
// ----------------------------------------------------------------------------
// b64d_group_unit
// Sextet lookup, group accumulation and the result register.
// ----------------------------------------------------------------------------
module b64d_group_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                hold_valid,
  input  b64d_pkg::in_item_t  hold_item,
  output logic                advance,
  output logic                out_valid,
  output b64d_pkg::out_item_t out_item,
  input  logic                out_stall
);

  logic [17:0]         store_r, store_nxt;
  logic [1:0]          held_r, held_nxt;
  logic [2:0]          pad_r, pad_nxt;
  logic                finished_r, finished_nxt;
  logic                out_valid_r, out_valid_nxt;
  b64d_pkg::out_item_t out_item_r, out_item_nxt;

  b64d_pkg::map_t      m;
  logic                fire;
  logic                eot;
  logic [2:0]          pad_a;
  logic [17:0]         store_a;
  logic [1:0]          held_a;
  logic                emit;

  assign advance = !out_valid_r || !out_stall;
  assign fire    = hold_valid && advance;
  assign eot     = hold_item.end_of_text;
  assign m       = b64d_pkg::map_char(hold_item.char_code);

  assign pad_a   = (m.hit && m.is_pad && pad_r < b64d_pkg::PAD_MAX) ? pad_r + 3'd1 : pad_r;
  assign store_a = {store_r[11:0], m.sextet};
  assign held_a  = held_r + 2'd1;

  always_comb begin
    store_nxt    = store_r;
    held_nxt     = held_r;
    pad_nxt      = pad_r;
    finished_nxt = finished_r;
    emit         = 1'b0;
    out_item_nxt = b64d_pkg::make_result(24'd0, 2'd0, 1'b1, 1'b0);
    if (finished_r) begin
      // padded group already out: skip until end of text
      if (eot) begin
        emit         = 1'b1;
        finished_nxt = 1'b0;
      end
    end else if (m.hit && held_r == b64d_pkg::HELD_FULL) begin
      emit         = 1'b1;
      out_item_nxt = b64d_pkg::make_result({store_r, m.sextet},
                                           b64d_pkg::count_for_pad(pad_a), eot, 1'b0);
      store_nxt    = 18'd0;
      held_nxt     = 2'd0;
      pad_nxt      = 3'd0;
      finished_nxt = !eot && (pad_a != 3'd0);
    end else begin
      if (m.hit) begin
        store_nxt = store_a;
        held_nxt  = held_a;
        pad_nxt   = pad_a;
      end
      if (eot) begin
        emit = 1'b1;
        case (held_nxt)
          2'd0: out_item_nxt = b64d_pkg::make_result(24'd0, 2'd0, 1'b1, 1'b0);
          2'd1: out_item_nxt = b64d_pkg::make_result(24'd0, 2'd0, 1'b1, 1'b1);
          2'd2: out_item_nxt = b64d_pkg::make_result({store_nxt[11:0], 12'd0}, 2'd1,
                                                     1'b1, 1'b0);
          default: out_item_nxt = b64d_pkg::make_result({store_nxt, 6'd0},
                                                        (pad_nxt == 3'd0) ? 2'd2 : 2'd1,
                                                        1'b1, 1'b0);
        endcase
        store_nxt = 18'd0;
        held_nxt  = 2'd0;
        pad_nxt   = 3'd0;
      end
    end
  end

  assign out_valid_nxt = advance ? (fire && emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r     <= 18'd0;
      held_r      <= 2'd0;
      pad_r       <= 3'd0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        store_r    <= store_nxt;
        held_r     <= held_nxt;
        pad_r      <= pad_nxt;
        finished_r <= finished_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_finished_empty: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> (held_r == 2'd0 && pad_r == 3'd0))
    else $error("finished group still holds sextets");

  a_eot_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && eot |=> out_valid_r && out_item_r.last_group)
    else $error("end of text gave no last result");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && eot |=> (held_r == 2'd0 && pad_r == 3'd0 && !finished_r))
    else $error("state not cleared after end of text");

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.bad_length |-> (out_item_r.last_group
                                              && out_item_r.byte_count == 2'd0))
    else $error("bad length flag on a non-empty or non-last result");

endmodule

[sv/base64_stream_decoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 decoder, standard and URL-safe alphabets, one character per item.
// ----------------------------------------------------------------------------
// An item enters the input register; its result is then registered for output.
// Throughput: one item per cycle while out_stall is low; the input register
// and the result register are the only stages; the group state is registered.
// Reset: synchronous, active low; clears the partial group, pad count and both
// stage valids. No clearing pass.
module base64_stream_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  b64d_pkg::in_item_t  in_item,
  output logic                in_stall,
  output logic                out_valid,
  output b64d_pkg::out_item_t out_item,
  input  logic                out_stall
);

  logic               advance;
  logic               hold_valid;
  b64d_pkg::in_item_t hold_item;

  b64d_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  b64d_group_unit u_group_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .out_stall  (out_stall)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_stream_decoder. A table of directed texts
// covers the alphabet ends, padding and the end-of-text corner cases. Random
// texts follow: mostly well-formed base64, some broken and some pure noise.
// Each accepted result is compared with the row's expected value or a local
// decoder model. Idle gaps and output stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 240;
  localparam int PHASE_ITEMS    = 288;
  localparam int NUM_PHASES     = 4;
  localparam int DIR_COUNT      = 27;

  localparam b64d_pkg::out_item_t NO_RESULT  = '0;
  localparam b64d_pkg::out_item_t EMPTY_LAST = {24'h0, 2'd0, 1'b1, 1'b0};
  localparam b64d_pkg::out_item_t LONE_LAST  = {24'h0, 2'd0, 1'b1, 1'b1};

  typedef struct packed {
    logic [7:0]          c;
    logic                eot;
    logic                typed;  // want holds the result this row must produce
    b64d_pkg::out_item_t want;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    {8'h00, 1'b1, 1'b1, EMPTY_LAST},
    {"z",   1'b1, 1'b1, LONE_LAST},
    {"/",   1'b0, 1'b0, NO_RESULT},
    {"/",   1'b0, 1'b0, NO_RESULT},
    {"/",   1'b0, 1'b0, NO_RESULT},
    {"/",   1'b0, 1'b1, {8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b0, 1'b0}},
    {"-",   1'b0, 1'b0, NO_RESULT},
    {"_",   1'b0, 1'b0, NO_RESULT},
    {"9",   1'b0, 1'b0, NO_RESULT},
    {"0",   1'b0, 1'b0, NO_RESULT},
    {8'hFF, 1'b1, 1'b1, EMPTY_LAST},
    {"A",   1'b0, 1'b0, NO_RESULT},
    {"A",   1'b0, 1'b0, NO_RESULT},
    {"A",   1'b0, 1'b0, NO_RESULT},
    {"A",   1'b1, 1'b1, {24'h0, 2'd3, 1'b1, 1'b0}},
    {"Q",   1'b0, 1'b0, NO_RESULT},
    {"Q",   1'b0, 1'b0, NO_RESULT},
    {b64d_pkg::CHAR_PAD, 1'b0, 1'b0, NO_RESULT},
    {b64d_pkg::CHAR_PAD, 1'b0, 1'b0, NO_RESULT},
    {"Z",   1'b0, 1'b0, NO_RESULT},
    {"~",   1'b1, 1'b1, EMPTY_LAST},
    {"T",   1'b0, 1'b0, NO_RESULT},
    {"W",   1'b0, 1'b0, NO_RESULT},
    {"E",   1'b1, 1'b0, NO_RESULT},
    {"a",   1'b0, 1'b0, NO_RESULT},
    {b64d_pkg::CHAR_PAD, 1'b0, 1'b0, NO_RESULT},
    {"b",   1'b1, 1'b0, NO_RESULT}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  b64d_pkg::in_item_t  in_item = '0;
  logic                in_stall;
  logic                out_valid;
  b64d_pkg::out_item_t out_item;
  logic                out_stall = 1'b0;

  // decoder model state
  logic [17:0] grp_bits = '0;
  logic [1:0]  grp_held = '0;
  logic [2:0]  grp_pads = '0;
  logic        grp_closed = 1'b0;

  logic       char_ok [256];
  logic [5:0] char_sextet [256];

  b64d_pkg::out_item_t result_q [$];
  b64d_pkg::in_item_t  text_q [$];

  int errors = 0;
  int items_sent = 0;
  int texts_sent = 0;
  int results_checked = 0;
  int lone_ends = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int stalled_cycles = 0;

  base64_stream_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  always #6 clk = ~clk;

  function automatic b64d_pkg::out_item_t pack_bytes(input logic [23:0] bits,
                                                     input logic [1:0] n,
                                                     input logic last, input logic bad);
    b64d_pkg::out_item_t r;
    r = '0;
    r.byte_count = n;
    r.last_group = last;
    r.bad_length = bad;
    if (n != 2'd0) r.byte_first  = bits[23:16];
    if (n >= 2'd2) r.byte_second = bits[15:8];
    if (n == 2'd3) r.byte_third  = bits[7:0];
    return r;
  endfunction

  // Advances the model by one character; returns 1 when a result is due.
  function automatic bit decode_step(input b64d_pkg::in_item_t it,
                                     output b64d_pkg::out_item_t res);
    logic [5:0] sx;
    logic       eot;
    bit         emitted;
    sx = char_sextet[it.char_code];
    eot = it.end_of_text;
    res = '0;
    emitted = 1'b0;
    if (grp_closed) begin
      if (eot) begin
        res = pack_bytes(24'h0, 2'd0, 1'b1, 1'b0);
        emitted = 1'b1;
        grp_closed = 1'b0;
      end
    end else begin
      if (char_ok[it.char_code]) begin
        if (it.char_code == b64d_pkg::CHAR_PAD && grp_pads != b64d_pkg::PAD_MAX) grp_pads++;
        if (grp_held == b64d_pkg::HELD_FULL) begin
          res = pack_bytes({grp_bits, sx},
                           (grp_pads == 3'd0) ? 2'd3 : (grp_pads == 3'd1) ? 2'd2 : 2'd1,
                           eot, 1'b0);
          emitted = 1'b1;
          grp_closed = (grp_pads != 3'd0) && !eot;
          grp_bits = '0;
          grp_held = '0;
          grp_pads = '0;
        end else begin
          grp_bits = {grp_bits[11:0], sx};
          grp_held++;
        end
      end
      if (eot && !emitted) begin
        case (grp_held)
          2'd0:    res = pack_bytes(24'h0, 2'd0, 1'b1, 1'b0);
          2'd1:    res = pack_bytes(24'h0, 2'd0, 1'b1, 1'b1);
          2'd2:    res = pack_bytes({grp_bits[11:0], 12'h0}, 2'd1, 1'b1, 1'b0);
          default: res = pack_bytes({grp_bits, 6'h0}, (grp_pads == 3'd0) ? 2'd2 : 2'd1,
                                    1'b1, 1'b0);
        endcase
        emitted = 1'b1;
        grp_bits = '0;
        grp_held = '0;
        grp_pads = '0;
      end
    end
    return emitted;
  endfunction

  function automatic logic [7:0] pick_char(input bit url);
    int idx;
    idx = $urandom_range(0, 63);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    if (idx == 62) return url ? "-" : "+";
    return url ? "_" : "/";
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (char_ok[c]);
    return c;
  endfunction

  task automatic send_item(input b64d_pkg::in_item_t it, input bit typed,
                           input b64d_pkg::out_item_t want);
    b64d_pkg::out_item_t got;
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (decode_step(it, got) && !typed) result_q.push_back(got);
    if (typed) result_q.push_back(want);
    items_sent++;
  endtask

  // Builds one text: mostly well-formed, otherwise broken or raw noise.
  task automatic build_text();
    int kind;
    int groups;
    int tail;
    int n;
    bit url;
    kind = $urandom_range(1, 100);
    url = 1'($urandom_range(0, 1));
    text_q.delete();
    if (kind <= 60) begin
      groups = ($urandom_range(1, 10) == 1) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      tail = $urandom_range(0, 3);
      for (n = 0; n < groups * 4 + tail; n++) begin
        if ($urandom_range(1, 20) == 1) text_q.push_back({pick_junk(), 1'b0});
        text_q.push_back({pick_char(url), 1'b0});
      end
      if (tail >= 2 && $urandom_range(0, 3) != 0)
        repeat (4 - tail) text_q.push_back({b64d_pkg::CHAR_PAD, 1'b0});
      if ($urandom_range(1, 8) == 1) text_q.push_back({pick_char(url), 1'b0});
      if ($urandom_range(1, 8) == 1) text_q.push_back({pick_junk(), 1'b0});
    end else if (kind <= 85) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 3))
          0:       text_q.push_back({b64d_pkg::CHAR_PAD, 1'b0});
          1:       text_q.push_back({pick_junk(), 1'b0});
          default: text_q.push_back({pick_char(url), 1'b0});
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 10))
        text_q.push_back({8'($urandom_range(0, 255)), 1'($urandom_range(1, 10) == 1)});
    end
    if (text_q.size() == 0) text_q.push_back({pick_char(url), 1'b0});
    text_q[text_q.size() - 1].end_of_text = 1'b1;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input b64d_pkg::out_item_t got);
    b64d_pkg::out_item_t want;
    if (result_q.size() == 0) begin
      $display("%0t: result %h arrived with none expected", $time, got);
      errors++;
      return;
    end
    want = result_q.pop_front();
    results_checked++;
    if (got.bad_length === 1'b1) lone_ends++;
    cmp_field("byte_first",  want.byte_first,  got.byte_first);
    cmp_field("byte_second", want.byte_second, got.byte_second);
    cmp_field("byte_third",  want.byte_third,  got.byte_third);
    cmp_field("byte_count",  8'(want.byte_count), 8'(got.byte_count));
    cmp_field("last_group",  8'(want.last_group), 8'(got.last_group));
    cmp_field("bad_length",  8'(want.bad_length), 8'(got.bad_length));
  endtask

  // result side: check, then pick the stall for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) check_result(out_item);
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (in_valid && in_stall === 1'b1) stalled_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int i;
    int k;
    int p;
    int start;
    int nth;
    int sender_pct [NUM_PHASES];
    int recv_pct [NUM_PHASES];
    sender_pct = '{0, 71, 0, 25};
    recv_pct   = '{0, 0, 71, 25};
    for (i = 0; i < 256; i++) begin
      char_ok[i] = 1'b0;
      char_sextet[i] = 6'd0;
    end
    for (i = 0; i < 26; i++) begin
      char_ok[8'h41 + i] = 1'b1;
      char_sextet[8'h41 + i] = 6'(i);
      char_ok[8'h61 + i] = 1'b1;
      char_sextet[8'h61 + i] = 6'(26 + i);
    end
    for (i = 0; i < 10; i++) begin
      char_ok[8'h30 + i] = 1'b1;
      char_sextet[8'h30 + i] = 6'(52 + i);
    end
    char_ok["+"] = 1'b1;  char_sextet["+"] = b64d_pkg::SEXTET_62;
    char_ok["-"] = 1'b1;  char_sextet["-"] = b64d_pkg::SEXTET_62;
    char_ok["/"] = 1'b1;  char_sextet["/"] = b64d_pkg::SEXTET_63;
    char_ok["_"] = 1'b1;  char_sextet["_"] = b64d_pkg::SEXTET_63;
    char_ok[b64d_pkg::CHAR_PAD] = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_COUNT; k++) begin
      send_item({DIR_ROWS[k].c, DIR_ROWS[k].eot}, DIR_ROWS[k].typed, DIR_ROWS[k].want);
      if (DIR_ROWS[k].eot) texts_sent++;
    end
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = sender_pct[p];
      recv_stall_pct = recv_pct[p];
      start = items_sent;
      nth = 0;
      while (items_sent - start < PHASE_ITEMS) begin
        // long output hold-off while input keeps coming, so the block backs up
        if (p == 0 && nth == 3) hold_requests++;
        // sender goes quiet until every pending result is out
        if (p == 1 && nth == 3) wait_drained();
        build_text();
        foreach (text_q[j]) send_item(text_q[j], 1'b0, NO_RESULT);
        texts_sent++;
        nth++;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("tb: %0d texts, %0d items, %0d results checked, %0d lone-sextet ends",
             texts_sent, items_sent, results_checked, lone_ends);
    $display("tb: input stalled for %0d cycles under back-pressure", stalled_cycles);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[base64_stream_decoder.f]
sv/b64d_pkg.sv
sv/b64d_in_stage.sv
sv/b64d_group_unit.sv
sv/base64_stream_decoder.sv
test/tb.sv
